// ===== rtl/qrv_pkg.sv =====
// Shared types and constants for the quaternion vector rotation pipeline.
// No dependencies; every other file in rtl/ imports this package.
package qrv_pkg;

    // Component width and quaternion fraction bits
    localparam int COMP_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;

    // First product: component x component, then a sum of three
    localparam int P1_W = 2 * COMP_WIDTH;
    localparam int T_W  = P1_W + 2;

    // Second product: component x first-product term, then a sum of four
    localparam int P2_W = COMP_WIDTH + T_W;
    localparam int R_W  = P2_W + 2;

    // Scale-back shift and round constant
    localparam int SCALE_SHIFT = 2 * QUAT_FRAC_BITS;

    // Stream word widths, padded to whole bytes
    localparam int IN_FIELDS_W  = 7 * COMP_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * COMP_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [P1_W-1:0]       prod1_t;
    typedef logic signed [T_W-1:0]        tsum_t;
    typedef logic signed [P2_W-1:0]       prod2_t;
    typedef logic signed [R_W-1:0]        rsum_t;

    // Saturation limits and rounding half, at the wide sum width
    localparam rsum_t ROT_MAX    = {{(R_W-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    localparam rsum_t ROT_MIN    = {{(R_W-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};
    localparam rsum_t ROUND_HALF = {{(R_W-1){1'b0}}, 1'b1} << (SCALE_SHIFT - 1);

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_t;

    typedef struct packed {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    // t = q * (0, v), full precision
    typedef struct packed {
        tsum_t w;
        tsum_t x;
        tsum_t y;
        tsum_t z;
    } tquat_t;

    // Rotated vector after rounding shift, not yet saturated
    typedef struct packed {
        rsum_t x;
        rsum_t y;
        rsum_t z;
    } rvec_t;

    // Final result word
    typedef struct packed {
        vec_t rot;
        logic saturated;
    } result_t;

endpackage

// ===== rtl/qrv_left_mul.sv =====
// Left Hamilton product t = q * (0, v): a product stage and a sum stage.
// Depends on qrv_pkg.
module qrv_left_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qrv_pkg::vec_t  in_vec,
    input  qrv_pkg::quat_t in_quat,
    output logic           out_valid,
    input  logic           out_ready,
    output qrv_pkg::tquat_t out_t,
    output qrv_pkg::quat_t out_quat
);
    import qrv_pkg::*;

    logic   prod_valid_reg;
    logic   sum_valid_reg;
    logic   prod_ready;
    logic   sum_ready;
    quat_t  prod_quat_reg;
    quat_t  sum_quat_reg;
    tquat_t sum_t_reg;
    tquat_t sum_t_next;

    // products: x*vx, y*vy, z*vz, then the cross and scaled terms
    prod1_t p_avx_reg, p_bvy_reg, p_cvz_reg;
    prod1_t p_bvz_reg, p_cvy_reg, p_wvx_reg;
    prod1_t p_cvx_reg, p_avz_reg, p_wvy_reg;
    prod1_t p_avy_reg, p_bvx_reg, p_wvz_reg;

    // ready chain back from the output
    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= in_valid;
            if (sum_ready)
                sum_valid_reg <= prod_valid_reg;
        end
    end

    // stage 1: twelve component products
    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
        begin
            p_avx_reg     <= prod1_t'(in_quat.x) * prod1_t'(in_vec.x);
            p_bvy_reg     <= prod1_t'(in_quat.y) * prod1_t'(in_vec.y);
            p_cvz_reg     <= prod1_t'(in_quat.z) * prod1_t'(in_vec.z);
            p_bvz_reg     <= prod1_t'(in_quat.y) * prod1_t'(in_vec.z);
            p_cvy_reg     <= prod1_t'(in_quat.z) * prod1_t'(in_vec.y);
            p_wvx_reg     <= prod1_t'(in_quat.w) * prod1_t'(in_vec.x);
            p_cvx_reg     <= prod1_t'(in_quat.z) * prod1_t'(in_vec.x);
            p_avz_reg     <= prod1_t'(in_quat.x) * prod1_t'(in_vec.z);
            p_wvy_reg     <= prod1_t'(in_quat.w) * prod1_t'(in_vec.y);
            p_avy_reg     <= prod1_t'(in_quat.x) * prod1_t'(in_vec.y);
            p_bvx_reg     <= prod1_t'(in_quat.y) * prod1_t'(in_vec.x);
            p_wvz_reg     <= prod1_t'(in_quat.w) * prod1_t'(in_vec.z);
            prod_quat_reg <= in_quat;
        end
    end

    // stage 2 sums: scalar part is minus the dot product
    always_comb
    begin
        sum_t_next.w = -(tsum_t'(p_avx_reg) + tsum_t'(p_bvy_reg) + tsum_t'(p_cvz_reg));
        sum_t_next.x = tsum_t'(p_bvz_reg) - tsum_t'(p_cvy_reg) + tsum_t'(p_wvx_reg);
        sum_t_next.y = tsum_t'(p_cvx_reg) - tsum_t'(p_avz_reg) + tsum_t'(p_wvy_reg);
        sum_t_next.z = tsum_t'(p_avy_reg) - tsum_t'(p_bvx_reg) + tsum_t'(p_wvz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && prod_valid_reg)
        begin
            sum_t_reg    <= sum_t_next;
            sum_quat_reg <= prod_quat_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_t     = sum_t_reg;
    assign out_quat  = sum_quat_reg;

endmodule

// ===== rtl/qrv_right_mul.sv =====
// Right product by conj(q), vector part only, then round and scale back.
// Depends on qrv_pkg.
module qrv_right_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qrv_pkg::tquat_t in_t,
    input  qrv_pkg::quat_t  in_quat,
    output logic            out_valid,
    input  logic            out_ready,
    output qrv_pkg::rvec_t  out_r
);
    import qrv_pkg::*;

    logic  prod_valid_reg;
    logic  sum_valid_reg;
    logic  prod_ready;
    logic  sum_ready;
    rvec_t sum_r_reg;
    rvec_t sum_r_next;
    rsum_t raw_x;
    rsum_t raw_y;
    rsum_t raw_z;

    // x row: y*tz, z*ty, w*tx, tw*x (same pattern for y and z rows)
    prod2_t p_btz_reg, p_cty_reg, p_wtx_reg, p_twa_reg;
    prod2_t p_ctx_reg, p_atz_reg, p_wty_reg, p_twb_reg;
    prod2_t p_aty_reg, p_btx_reg, p_wtz_reg, p_twc_reg;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= in_valid;
            if (sum_ready)
                sum_valid_reg <= prod_valid_reg;
        end
    end

    // stage 3: twelve quaternion-by-t products
    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
        begin
            p_btz_reg <= prod2_t'(in_quat.y) * prod2_t'(in_t.z);
            p_cty_reg <= prod2_t'(in_quat.z) * prod2_t'(in_t.y);
            p_wtx_reg <= prod2_t'(in_quat.w) * prod2_t'(in_t.x);
            p_twa_reg <= prod2_t'(in_quat.x) * prod2_t'(in_t.w);
            p_ctx_reg <= prod2_t'(in_quat.z) * prod2_t'(in_t.x);
            p_atz_reg <= prod2_t'(in_quat.x) * prod2_t'(in_t.z);
            p_wty_reg <= prod2_t'(in_quat.w) * prod2_t'(in_t.y);
            p_twb_reg <= prod2_t'(in_quat.y) * prod2_t'(in_t.w);
            p_aty_reg <= prod2_t'(in_quat.x) * prod2_t'(in_t.y);
            p_btx_reg <= prod2_t'(in_quat.y) * prod2_t'(in_t.x);
            p_wtz_reg <= prod2_t'(in_quat.w) * prod2_t'(in_t.z);
            p_twc_reg <= prod2_t'(in_quat.z) * prod2_t'(in_t.w);
        end
    end

    // stage 4: cross + scaled - tw*u, add half, arithmetic shift
    always_comb
    begin
        raw_x = rsum_t'(p_btz_reg) - rsum_t'(p_cty_reg) + rsum_t'(p_wtx_reg)
                - rsum_t'(p_twa_reg) + ROUND_HALF;
        raw_y = rsum_t'(p_ctx_reg) - rsum_t'(p_atz_reg) + rsum_t'(p_wty_reg)
                - rsum_t'(p_twb_reg) + ROUND_HALF;
        raw_z = rsum_t'(p_aty_reg) - rsum_t'(p_btx_reg) + rsum_t'(p_wtz_reg)
                - rsum_t'(p_twc_reg) + ROUND_HALF;
        sum_r_next.x = raw_x >>> SCALE_SHIFT;
        sum_r_next.y = raw_y >>> SCALE_SHIFT;
        sum_r_next.z = raw_z >>> SCALE_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (sum_ready && prod_valid_reg)
            sum_r_reg <= sum_r_next;
    end

    assign out_valid = sum_valid_reg;
    assign out_r     = sum_r_reg;

endmodule

// ===== rtl/qrv_saturate.sv =====
// Output stage: clip each component to the signed component range and hold
// the result word for the downstream side. Depends on qrv_pkg.
module qrv_saturate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qrv_pkg::rvec_t   in_r,
    output logic             out_valid,
    input  logic             out_ready,
    output qrv_pkg::result_t out_res
);
    import qrv_pkg::*;

    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;

    assign in_ready = !res_valid_reg || out_ready;

    // clip detect and limit selection
    always_comb
    begin
        hi_x = in_r.x > ROT_MAX;
        lo_x = in_r.x < ROT_MIN;
        hi_y = in_r.y > ROT_MAX;
        lo_y = in_r.y < ROT_MIN;
        hi_z = in_r.z > ROT_MAX;
        lo_z = in_r.z < ROT_MIN;
        res_next.rot.x = hi_x ? comp_t'(ROT_MAX) : (lo_x ? comp_t'(ROT_MIN) : comp_t'(in_r.x));
        res_next.rot.y = hi_y ? comp_t'(ROT_MAX) : (lo_y ? comp_t'(ROT_MIN) : comp_t'(in_r.y));
        res_next.rot.z = hi_z ? comp_t'(ROT_MAX) : (lo_z ? comp_t'(ROT_MIN) : comp_t'(in_r.z));
        res_next.saturated = hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (in_ready)
            res_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/quaternion_rotate_vector.sv =====
// Quaternion vector rotation: returns the vector part of q * (0, v) * conj(q)
// in fixed point. Each input word carries one vector (signed integers) and
// one quaternion (signed Q1.14, not normalised, so a non-unit q scales the
// result by |q|^2). The block accepts one word per clock unless back-pressure
// stalls the pipeline; the five register stages are the first product layer,
// its sums, the second product layer, the rounded sums and the saturating
// output register. The result is rounded to nearest with ties upward and
// clipped to 16 bits, with tuser flagging any clip. Back-pressure
// stalls each stage only while it holds a word, so bubbles are squeezed out.
// Depends on qrv_pkg, qrv_left_mul, qrv_right_mul and qrv_saturate.
module quaternion_rotate_vector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w (lowest first)
    input  logic [qrv_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // rot_x, rot_y, rot_z (lowest first), any padding above is zero
    output logic [qrv_pkg::OUT_TDATA_W-1:0] m_tdata,
    // saturated
    output logic                            m_tuser
);
    import qrv_pkg::*;

    vec_t    in_vec;
    quat_t   in_quat;
    logic    t_valid;
    logic    t_ready;
    tquat_t  t_val;
    quat_t   t_quat;
    logic    r_valid;
    logic    r_ready;
    rvec_t   r_val;
    result_t res;

    // unpack the input word
    assign in_vec.x  = comp_t'(s_tdata[0*COMP_WIDTH +: COMP_WIDTH]);
    assign in_vec.y  = comp_t'(s_tdata[1*COMP_WIDTH +: COMP_WIDTH]);
    assign in_vec.z  = comp_t'(s_tdata[2*COMP_WIDTH +: COMP_WIDTH]);
    assign in_quat.x = comp_t'(s_tdata[3*COMP_WIDTH +: COMP_WIDTH]);
    assign in_quat.y = comp_t'(s_tdata[4*COMP_WIDTH +: COMP_WIDTH]);
    assign in_quat.z = comp_t'(s_tdata[5*COMP_WIDTH +: COMP_WIDTH]);
    assign in_quat.w = comp_t'(s_tdata[6*COMP_WIDTH +: COMP_WIDTH]);

    qrv_left_mul u_left_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_vec    (in_vec),
        .in_quat   (in_quat),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_t     (t_val),
        .out_quat  (t_quat)
    );

    qrv_right_mul u_right_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_t      (t_val),
        .in_quat   (t_quat),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_r     (r_val)
    );

    qrv_saturate u_saturate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_r      (r_val),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the result word
    assign m_tdata = OUT_TDATA_W'({res.rot.z, res.rot.y, res.rot.x});
    assign m_tuser = res.saturated;

endmodule
